// File: rtl/core/atrp_pkg.sv
// Shared constants, register indexes and the arctangent table of the tilt block.
package atrp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int SQRT_STAGES   = 24;
  localparam int CORDIC_LAT    = CORDIC_STAGES + 1;
  localparam int ACC_DLY       = 2 + SQRT_STAGES + CORDIC_LAT;
  localparam int CX_W          = 28;
  localparam int ANG_W         = 32;

  localparam logic [1:0] REG_SCALE    = 2'd0;
  localparam logic [1:0] REG_X_OFFSET = 2'd1;
  localparam logic [1:0] REG_Y_OFFSET = 2'd2;
  localparam logic [1:0] REG_Z_OFFSET = 2'd3;

  localparam logic [15:0] SCALE_RESET = 16'd250;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      0:       a = 32'sd843314857;
      1:       a = 32'sd497837829;
      2:       a = 32'sd263043837;
      3:       a = 32'sd133525159;
      4:       a = 32'sd67021687;
      5:       a = 32'sd33543516;
      6:       a = 32'sd16775851;
      7:       a = 32'sd8388437;
      8:       a = 32'sd4194283;
      9:       a = 32'sd2097149;
      10:      a = 32'sd1048576;
      11:      a = 32'sd524288;
      12:      a = 32'sd262144;
      13:      a = 32'sd131072;
      14:      a = 32'sd65536;
      15:      a = 32'sd32768;
      16:      a = 32'sd16384;
      17:      a = 32'sd8192;
      18:      a = 32'sd4096;
      19:      a = 32'sd2048;
      20:      a = 32'sd1024;
      21:      a = 32'sd512;
      22:      a = 32'sd256;
      23:      a = 32'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/atrp_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
module atrp_isqrt (
  input  logic        clk_i,
  input  logic [47:0] val_i,
  output logic [23:0] root_o
);

  logic [47:0] rem_q [atrp_pkg::SQRT_STAGES];
  logic [47:0] res_q [atrp_pkg::SQRT_STAGES];

  for (genvar s = 0; s < atrp_pkg::SQRT_STAGES; s++) begin : g_stage
    localparam logic [47:0] Bit = 48'd1 << (2 * (atrp_pkg::SQRT_STAGES - 1 - s));
    logic [47:0] rem_in;
    logic [47:0] res_in;
    logic [47:0] trial;
    if (s == 0) begin : g_first
      assign rem_in = val_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign res_in = res_q[s-1];
    end
    assign trial = res_in + Bit;
    always_ff @(posedge clk_i) begin
      if (rem_in >= trial) begin
        rem_q[s] <= rem_in - trial;
        res_q[s] <= (res_in >> 1) + Bit;
      end else begin
        rem_q[s] <= rem_in;
        res_q[s] <= res_in >> 1;
      end
    end
  end

  assign root_o = res_q[atrp_pkg::SQRT_STAGES-1][23:0];

endmodule

// File: rtl/core/atrp_cordic.sv
// Pipelined vectoring CORDIC that gives atan2(num, den) in Q3.13 radians.
module atrp_cordic (
  input  logic               clk_i,
  input  logic signed [23:0] num_i,
  input  logic [23:0]        den_i,
  output logic signed [15:0] angle_o
);

  localparam int N = atrp_pkg::CORDIC_STAGES;
  localparam int W = atrp_pkg::CX_W;
  localparam int A = atrp_pkg::ANG_W;

  logic signed [W-1:0] x_q   [N];
  logic signed [W-1:0] y_q   [N];
  logic signed [A-1:0] ang_q [N];
  logic                zero_q[N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [W-1:0] x_in;
    logic signed [W-1:0] y_in;
    logic signed [A-1:0] ang_in;
    logic                zero_in;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    if (i == 0) begin : g_first
      assign x_in    = W'(signed'({1'b0, den_i}));
      assign y_in    = W'(num_i);
      assign ang_in  = '0;
      assign zero_in = (num_i == '0);
    end else begin : g_next
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign ang_in  = ang_q[i-1];
      assign zero_in = zero_q[i-1];
    end
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    always_ff @(posedge clk_i) begin
      zero_q[i] <= zero_in;
      if (y_in < 0) begin
        x_q[i]   <= x_in - dx;
        y_q[i]   <= y_in + dy;
        ang_q[i] <= ang_in - atrp_pkg::atan_q30(i);
      end else begin
        x_q[i]   <= x_in + dx;
        y_q[i]   <= y_in - dy;
        ang_q[i] <= ang_in + atrp_pkg::atan_q30(i);
      end
    end
  end

  logic signed [A-1:0] rnd;
  logic signed [A-1:0] shifted;
  logic signed [15:0]  angle_q;

  assign rnd     = ang_q[N-1] + A'(65536);
  assign shifted = rnd >>> 17;

  always_ff @(posedge clk_i) begin
    angle_q <= zero_q[N-1] ? '0 : shifted[15:0];
  end

  assign angle_o = angle_q;

endmodule

// File: rtl/core/accel_tilt_roll_pitch.sv
// Top level of the accelerometer tilt block: axis correction, roll and pitch.
//
// Raise start for one cycle with a raw sample on raw_x_i, raw_y_i and raw_z_i;
// the item is taken at that edge. busy is always low, so a new item can be
// given in every cycle. Each item yields exactly one result, shown for one
// cycle with valid_o high on accel_x_o, accel_y_o, accel_z_o, roll_o and
// pitch_o. The receiver cannot hold results off.
// The path runs through the gain multiply and offset registers, the squares and sums
// registers, the square root pipeline (one root bit per stage), the CORDIC stages
// with the CORDIC output register, and one output register. Throughput is one
// item per cycle.
// Registers are written through cfg_we_i, cfg_addr_i and cfg_wdata_i:
// index 0 scale, 1 x_offset, 2 y_offset, 3 z_offset. Write them only while
// no item is in flight.
// Reset sets scale to 250, the offsets to zero and drops all items in flight.
module accel_tilt_roll_pitch (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic signed [15:0] raw_x_i,
  input  logic signed [15:0] raw_y_i,
  input  logic signed [15:0] raw_z_i,
  output logic               valid_o,
  output logic signed [23:0] accel_x_o,
  output logic signed [23:0] accel_y_o,
  output logic signed [23:0] accel_z_o,
  output logic signed [15:0] roll_o,
  output logic signed [15:0] pitch_o
);

  localparam int D   = atrp_pkg::ACC_DLY;
  localparam int TAP = 1 + atrp_pkg::SQRT_STAGES;

  logic [15:0]        scale_q;
  logic signed [23:0] off_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= atrp_pkg::SCALE_RESET;
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        atrp_pkg::REG_SCALE:    scale_q  <= cfg_wdata_i[15:0];
        atrp_pkg::REG_X_OFFSET: off_q[0] <= cfg_wdata_i;
        atrp_pkg::REG_Y_OFFSET: off_q[1] <= cfg_wdata_i;
        atrp_pkg::REG_Z_OFFSET: off_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic signed [15:0] raw [3];
  assign raw[0] = raw_x_i;
  assign raw[1] = raw_y_i;
  assign raw[2] = raw_z_i;

  logic               v1_q;
  logic               v2_q;
  logic [D-1:0]       v_dly_q;
  logic signed [32:0] prod_q [3];
  logic signed [23:0] acc_q  [3];
  logic [46:0]        sq_q   [3];
  logic [47:0]        syz_q;
  logic [47:0]        sxz_q;
  logic signed [23:0] dly_q  [D][3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [24:0] shr;
    logic signed [25:0] diff;
    logic signed [23:0] sat;
    logic signed [47:0] sqr;
    assign shr  = 25'(prod_q[a] >>> 8);
    assign diff = 26'(shr) - 26'(off_q[a]);
    always_comb begin
      if (diff > 26'sd8388607) begin
        sat = 24'sh7FFFFF;
      end else if (diff < -26'sd8388608) begin
        sat = 24'sh800000;
      end else begin
        sat = diff[23:0];
      end
    end
    assign sqr = 48'(acc_q[a]) * 48'(acc_q[a]);
    always_ff @(posedge clk_i) begin
      prod_q[a] <= 33'(raw[a]) * signed'({17'd0, scale_q});
      acc_q[a]  <= sat;
      sq_q[a]   <= sqr[46:0];
    end
  end

  always_ff @(posedge clk_i) begin
    syz_q <= {1'b0, sq_q[1]} + {1'b0, sq_q[2]};
    sxz_q <= {1'b0, sq_q[0]} + {1'b0, sq_q[2]};
    dly_q[0] <= acc_q;
    for (int j = 1; j < D; j++) begin
      dly_q[j] <= dly_q[j-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v_dly_q <= '0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= start;
      v2_q    <= v1_q;
      v_dly_q <= {v_dly_q[D-2:0], v2_q};
      valid_o <= v_dly_q[D-1];
    end
  end

  logic [23:0]        ryz;
  logic [23:0]        rxz;
  logic signed [15:0] roll_ang;
  logic signed [15:0] pitch_ang;

  atrp_isqrt u_sqrt_yz (.clk_i(clk_i), .val_i(syz_q), .root_o(ryz));
  atrp_isqrt u_sqrt_xz (.clk_i(clk_i), .val_i(sxz_q), .root_o(rxz));

  atrp_cordic u_cordic_roll (
    .clk_i  (clk_i),
    .num_i  (dly_q[TAP][0]),
    .den_i  (ryz),
    .angle_o(roll_ang)
  );

  atrp_cordic u_cordic_pitch (
    .clk_i  (clk_i),
    .num_i  (dly_q[TAP][1]),
    .den_i  (rxz),
    .angle_o(pitch_ang)
  );

  always_ff @(posedge clk_i) begin
    accel_x_o <= dly_q[D-1][0];
    accel_y_o <= dly_q[D-1][1];
    accel_z_o <= dly_q[D-1][2];
    roll_o    <= -roll_ang;
    pitch_o   <= pitch_ang;
  end

endmodule
